// File: sv/pidc_pkg.sv
// shared widths, register indexes, operation codes and types of the clamped pid controller
`timescale 1ns / 1ps

package pidc_pkg;

  // fixed point format and sample width
  localparam int FRAC_BITS    = 8;
  localparam int SAMPLE_WIDTH = 16;

  // field widths
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DRIVE_W = 16;

  // error and difference widths
  localparam int ERR_W   = SAMPLE_WIDTH + 1;
  localparam int DIFF1_W = SAMPLE_WIDTH + 2;
  localparam int DIFF2_W = SAMPLE_WIDTH + 3;

  // gain products and their rescaling from q8.8 to FRAC_BITS fraction bits
  localparam int PROD_W   = GAIN_W + 1 + DIFF2_W;
  localparam int SCALE_UP = (FRAC_BITS >= 8) ? (FRAC_BITS - 8) : 0;
  localparam int SCALE_DN = (FRAC_BITS >= 8) ? 0 : (8 - FRAC_BITS);
  localparam int TERM_W   = PROD_W + SCALE_UP;

  // accumulators and sums
  localparam int ACC_W = LIM_W + FRAC_BITS + 1;
  localparam int SUM_W = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 3;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BOUND = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = CFG_IDX_W'(5);

  localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

  // loop forms and operations
  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;
  localparam logic OP_STEP          = 1'b0;
  localparam logic OP_CLEAR         = 1'b1;

  // configuration register set
  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  output_limit;
    logic [LIM_W-1:0]  integral_bound;
    logic              loop_mode;
  } cfg_t;

  // scaled gain terms handed from the multiply stage to the accumulate stage
  typedef struct packed {
    logic                     clear;
    logic signed [TERM_W-1:0] pterm;
    logic signed [TERM_W-1:0] iterm;
    logic signed [TERM_W-1:0] dterm;
  } terms_t;

  // rescale a q8.8 gain product, flooring when bits are dropped
  function automatic logic signed [TERM_W-1:0] rescale(input logic signed [PROD_W-1:0] p);
    logic signed [TERM_W-1:0] w;
    w = TERM_W'(p);
    return (w <<< SCALE_UP) >>> SCALE_DN;
  endfunction

endpackage

// File: sv/pidc_if.sv
// valid/ready channels carrying the sample items and the result items
`timescale 1ns / 1ps

interface pidc_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    operation;
  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] measured;
  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] target;

  modport source (output valid, operation, measured, target, input ready);
  modport sink   (input valid, operation, measured, target, output ready);
endinterface

interface pidc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::DRIVE_W-1:0] drive;
  logic                               output_clamped;
  logic                               integral_clamped;

  modport source (output valid, drive, output_clamped, integral_clamped, input ready);
  modport sink   (input valid, drive, output_clamped, integral_clamped, output ready);
endinterface

// File: sv/pidc_terms.sv
// input register, error history and the three gain multipliers
`timescale 1ns / 1ps

module pidc_terms (
  input  logic               clk,
  input  logic               rst,
  input  pidc_pkg::cfg_t     cfg,
  pidc_sample_if.sink        sample,
  output logic               terms_valid,
  input  logic               terms_ready,
  output pidc_pkg::terms_t   terms
);

  logic                                     s1_valid;
  logic                                     s1_op;
  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] s1_meas;
  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] s1_tgt;
  logic                                     s1_ready;
  logic                                     s1_advance;
  logic                                     s2_ready;

  logic signed [pidc_pkg::ERR_W-1:0]   err;
  logic signed [pidc_pkg::ERR_W-1:0]   err_prev;
  logic signed [pidc_pkg::ERR_W-1:0]   err_prev2;
  logic signed [pidc_pkg::DIFF1_W-1:0] diff1;
  logic signed [pidc_pkg::DIFF2_W-1:0] diff2;
  logic signed [pidc_pkg::DIFF2_W-1:0] p_opnd;
  logic signed [pidc_pkg::DIFF2_W-1:0] d_opnd;

  logic signed [pidc_pkg::GAIN_W:0]   kp;
  logic signed [pidc_pkg::GAIN_W:0]   ki;
  logic signed [pidc_pkg::GAIN_W:0]   kd;
  logic signed [pidc_pkg::PROD_W-1:0] prod_p;
  logic signed [pidc_pkg::PROD_W-1:0] prod_i;
  logic signed [pidc_pkg::PROD_W-1:0] prod_d;

  // handshake between input register and term register
  assign s2_ready     = !terms_valid || terms_ready;
  assign s1_advance   = s1_valid && s2_ready;
  assign s1_ready     = !s1_valid || s2_ready;
  assign sample.ready = s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && s1_ready) begin
      s1_op   <= sample.operation;
      s1_meas <= sample.measured;
      s1_tgt  <= sample.target;
    end
  end

  // error and its differences against the history
  assign err   = pidc_pkg::ERR_W'(s1_tgt) - pidc_pkg::ERR_W'(s1_meas);
  assign diff1 = pidc_pkg::DIFF1_W'(err) - pidc_pkg::DIFF1_W'(err_prev);
  assign diff2 = pidc_pkg::DIFF2_W'(err) - (pidc_pkg::DIFF2_W'(err_prev) <<< 1)
               + pidc_pkg::DIFF2_W'(err_prev2);

  // operands differ between the positional and the incremental form
  assign p_opnd = (cfg.loop_mode == pidc_pkg::MODE_INCREMENTAL) ?
                  pidc_pkg::DIFF2_W'(diff1) : pidc_pkg::DIFF2_W'(err);
  assign d_opnd = (cfg.loop_mode == pidc_pkg::MODE_INCREMENTAL) ?
                  diff2 : pidc_pkg::DIFF2_W'(diff1);

  // gain multipliers, gains taken as non-negative
  assign kp     = {1'b0, cfg.prop_gain};
  assign ki     = {1'b0, cfg.integ_gain};
  assign kd     = {1'b0, cfg.deriv_gain};
  assign prod_p = kp * p_opnd;
  assign prod_i = ki * err;
  assign prod_d = kd * d_opnd;

  // error history, kept across clear items
  always_ff @(posedge clk) begin
    if (rst) begin
      err_prev  <= '0;
      err_prev2 <= '0;
    end else if (s1_advance && s1_op == pidc_pkg::OP_STEP) begin
      err_prev2 <= err_prev;
      err_prev  <= err;
    end
  end

  // term register
  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (s2_ready) begin
      terms_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      terms.clear <= (s1_op == pidc_pkg::OP_CLEAR);
      terms.pterm <= pidc_pkg::rescale(prod_p);
      terms.iterm <= pidc_pkg::rescale(prod_i);
      terms.dterm <= pidc_pkg::rescale(prod_d);
    end
  end

endmodule

// File: sv/pidc_accum.sv
// integral and output accumulators with their clamps, and the result register
`timescale 1ns / 1ps

module pidc_accum (
  input  logic             clk,
  input  logic             rst,
  input  pidc_pkg::cfg_t   cfg,
  input  logic             terms_valid,
  output logic             terms_ready,
  input  pidc_pkg::terms_t terms,
  pidc_result_if.source    result
);

  typedef struct packed {
    logic                             hit;
    logic signed [pidc_pkg::ACC_W-1:0] value;
  } clamp_t;

  // symmetric clamp at the limit in accumulator units
  function automatic clamp_t clamp_sym(input logic signed [pidc_pkg::SUM_W-1:0] v,
                                       input logic [pidc_pkg::LIM_W-1:0]        lim);
    logic signed [pidc_pkg::SUM_W-1:0] b;
    clamp_t                            r;
    b = signed'(pidc_pkg::SUM_W'(lim)) <<< pidc_pkg::FRAC_BITS;
    if (v > b) begin
      r.hit   = 1'b1;
      r.value = pidc_pkg::ACC_W'(b);
    end else if (v < -b) begin
      r.hit   = 1'b1;
      r.value = pidc_pkg::ACC_W'(-b);
    end else begin
      r.hit   = 1'b0;
      r.value = pidc_pkg::ACC_W'(v);
    end
    return r;
  endfunction

  logic signed [pidc_pkg::ACC_W-1:0] integ_acc;
  logic signed [pidc_pkg::ACC_W-1:0] out_acc;
  logic signed [pidc_pkg::SUM_W-1:0] integ_sum;
  logic signed [pidc_pkg::SUM_W-1:0] base;
  logic signed [pidc_pkg::SUM_W-1:0] out_sum;
  logic signed [pidc_pkg::ACC_W-1:0] out_next;
  logic signed [pidc_pkg::ACC_W-1:0] drive_full;
  clamp_t                            ic;
  clamp_t                            oc;
  logic                              incremental;
  logic                              advance;

  assign incremental = (cfg.loop_mode == pidc_pkg::MODE_INCREMENTAL);
  assign terms_ready = !result.valid || result.ready;
  assign advance     = terms_valid && terms_ready;

  // integral update and clamp
  assign integ_sum = pidc_pkg::SUM_W'(integ_acc) + pidc_pkg::SUM_W'(terms.iterm);
  assign ic        = clamp_sym(integ_sum, cfg.integral_bound);

  // output sum for either form, then clamp
  assign base    = incremental ? pidc_pkg::SUM_W'(out_acc) + pidc_pkg::SUM_W'(terms.iterm)
                               : pidc_pkg::SUM_W'(ic.value);
  assign out_sum = pidc_pkg::SUM_W'(terms.pterm) + pidc_pkg::SUM_W'(terms.dterm) + base;
  assign oc      = clamp_sym(out_sum, cfg.output_limit);

  assign out_next   = oc.value;
  assign drive_full = out_next >>> pidc_pkg::FRAC_BITS;

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      out_acc   <= '0;
    end else if (advance) begin
      if (terms.clear) begin
        integ_acc <= '0;
        out_acc   <= '0;
      end else begin
        out_acc <= out_next;
        if (!incremental) begin
          integ_acc <= ic.value;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (terms_ready) begin
      result.valid <= terms_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (terms.clear) begin
        result.drive            <= '0;
        result.output_clamped   <= 1'b0;
        result.integral_clamped <= 1'b0;
      end else begin
        result.drive            <= pidc_pkg::DRIVE_W'(drive_full);
        result.output_clamped   <= oc.hit;
        result.integral_clamped <= ic.hit && !incremental;
      end
    end
  end

endmodule

// File: sv/pid_controller_clamped.sv
// Clamped fixed-point PID controller, positional or incremental form.
// Channels: sample carries operation, measured and target; result carries
// drive, output_clamped and integral_clamped. Both are valid/ready, an item
// moving on an edge where valid and ready are high. Each sample item gives
// exactly one result item, in order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (gains, output limit, integral bound, loop mode); write only while idle.
// Path: an accepted item passes through the input register, the term
// register (three gain multipliers) and the result register (accumulate
// and clamp).
// Throughput: one item per cycle while result is not held; the accumulator
// feedback closes within the last stage, so consecutive items need no gap.
// Stall: a held result back-pressures stage by stage; sample.ready drops
// only once all three registers hold items.
// Reset: rst is synchronous, clears the pipeline, the error history and
// both accumulators, sets the gains to zero, both limits to full scale and
// the positional form.
`timescale 1ns / 1ps

module pid_controller_clamped (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data,
  pidc_sample_if.sink                         sample,
  pidc_result_if.source                       result
);

  pidc_pkg::cfg_t   cfg;
  pidc_pkg::terms_t terms;
  logic             terms_valid;
  logic             terms_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.integ_gain     <= '0;
      cfg.deriv_gain     <= '0;
      cfg.output_limit   <= pidc_pkg::LIMIT_RESET;
      cfg.integral_bound <= pidc_pkg::LIMIT_RESET;
      cfg.loop_mode      <= pidc_pkg::MODE_POSITIONAL;
    end else if (cfg_write) begin
      case (cfg_index)
        pidc_pkg::REG_PROP_GAIN: begin
          cfg.prop_gain <= cfg_data[pidc_pkg::GAIN_W-1:0];
        end
        pidc_pkg::REG_INTEG_GAIN: begin
          cfg.integ_gain <= cfg_data[pidc_pkg::GAIN_W-1:0];
        end
        pidc_pkg::REG_DERIV_GAIN: begin
          cfg.deriv_gain <= cfg_data[pidc_pkg::GAIN_W-1:0];
        end
        pidc_pkg::REG_OUTPUT_LIMIT: begin
          cfg.output_limit <= cfg_data[pidc_pkg::LIM_W-1:0];
        end
        pidc_pkg::REG_INTEGRAL_BOUND: begin
          cfg.integral_bound <= cfg_data[pidc_pkg::LIM_W-1:0];
        end
        pidc_pkg::REG_LOOP_MODE: begin
          cfg.loop_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // error, history and gain products
  pidc_terms u_terms (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .sample      (sample),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  // accumulators, clamps and result register
  pidc_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms),
    .result      (result)
  );

endmodule

// File: sv/pidc_checker.sv
// port-level checks of the clamped pid controller and their binding to it
`timescale 1ns / 1ps

module pidc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data,
  pidc_sample_if.sink                     sample,
  pidc_result_if.source                   result
);

  logic [pidc_pkg::LIM_W-1:0]          lim;
  logic signed [pidc_pkg::DRIVE_W-1:0] lim_pos;
  logic signed [pidc_pkg::DRIVE_W-1:0] lim_neg;

  // shadow of the output limit as seen on the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= pidc_pkg::LIMIT_RESET;
    end else if (cfg_write && cfg_index == pidc_pkg::REG_OUTPUT_LIMIT) begin
      lim <= cfg_data[pidc_pkg::LIM_W-1:0];
    end
  end

  assign lim_pos = signed'(pidc_pkg::DRIVE_W'(lim));
  assign lim_neg = -lim_pos;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // input only stalls when the result side is stalled with a full pipeline
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (result.valid && !result.ready))
    else $error("sample stalled without result back-pressure");

  // drive never leaves the output limit
  a_drive_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive <= lim_pos && result.drive >= lim_neg))
    else $error("drive beyond output limit");

  // a clamped output sits exactly on the limit
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.output_clamped) |->
      (result.drive == lim_pos || result.drive == lim_neg))
    else $error("clamped drive not on the limit");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .sample    (sample),
  .result    (result)
);
